FILE: rtl/fir_pkg.sv
package fir_pkg;

  // Filter geometry; Taps may range from 2 to 8
  localparam int Taps    = 8;
  localparam int NumRegs = 8;
  localparam int RegIdxW = $clog2(NumRegs);

  // Field widths
  localparam int SampleW = 16;
  localparam int CoeffW  = 16;
  localparam int ProdW   = SampleW + CoeffW;
  localparam int PairW   = ProdW + 1;
  localparam int OutW    = 35;

  // Products are summed in pairs first, then the pairs are summed
  localparam int NumPairs = (Taps + 1) / 2;

  // Queue between front and back; depth must be a power of two
  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // Coefficient reset values
  localparam logic [CoeffW-1:0] CoeffReset0    = 16'h7FFF;
  localparam logic [CoeffW-1:0] CoeffResetRest = 16'h0000;

  // One full sample window: element 0 is the newest sample
  typedef logic [Taps-1:0][SampleW-1:0] window_t;

  // Configuration write
  typedef struct packed {
    logic               we;
    logic [RegIdxW-1:0] idx;
    logic [CoeffW-1:0]  data;
  } cfg_wr_t;

endpackage

FILE: rtl/fir_front.sv
module fir_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              sample_valid_i,
  output logic                              sample_stall_o,
  input  logic [fir_pkg::SampleW-1:0]       sample_i,
  input  logic                              full_i,
  output logic                              push_o,
  output fir_pkg::window_t                  window_o
);

  logic [fir_pkg::SampleW-1:0] hist_q [fir_pkg::Taps-1];
  logic [fir_pkg::SampleW-1:0] hist_d [fir_pkg::Taps-1];

  // Accept a word whenever the queue has room
  assign sample_stall_o = full_i;
  assign push_o         = sample_valid_i && !full_i;

  // Build the window: new sample plus the previous ones
  always_comb begin
    window_o[0] = sample_i;
    for (int k = 1; k < fir_pkg::Taps; k++) begin
      window_o[k] = hist_q[k-1];
    end
  end

  // Advance the delay line on each accepted word
  always_comb begin
    hist_d[0] = sample_i;
    for (int k = 1; k < fir_pkg::Taps - 1; k++) begin
      hist_d[k] = hist_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < fir_pkg::Taps - 1; k++) begin
        hist_q[k] <= '0;
      end
    end else if (push_o) begin
      for (int k = 0; k < fir_pkg::Taps - 1; k++) begin
        hist_q[k] <= hist_d[k];
      end
    end
  end

  // The delay line holds still while a word is refused
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_o |=> $stable(hist_q[0]))
    else $error("delay line moved without an accepted word");

endmodule

FILE: rtl/fir_queue.sv
module fir_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fir_pkg::window_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output fir_pkg::window_t pop_data_o
);

  fir_pkg::window_t               mem_q [fir_pkg::FifoDepth];
  logic [fir_pkg::FifoPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [fir_pkg::FifoPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [fir_pkg::FifoCntW-1:0]   count_q, count_d;

  assign full_o     = (count_q == fir_pkg::FifoCntW'(fir_pkg::FifoDepth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Move pointers and count
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed window
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= fir_pkg::FifoCntW'(fir_pkg::FifoDepth))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from an empty queue");

endmodule

FILE: rtl/fir_back.sv
module fir_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fir_pkg::cfg_wr_t              cfg_i,
  input  logic                          valid_i,
  input  fir_pkg::window_t              window_i,
  output logic                          pop_o,
  output logic                          filtered_valid_o,
  input  logic                          filtered_stall_i,
  output logic [fir_pkg::OutW-1:0]      filtered_o
);

  logic [fir_pkg::CoeffW-1:0]        coeff_q [fir_pkg::NumRegs];
  logic signed [fir_pkg::ProdW-1:0]  prod_q  [fir_pkg::Taps];
  logic signed [fir_pkg::ProdW-1:0]  prod_d  [fir_pkg::Taps];
  logic signed [fir_pkg::PairW-1:0]  pair_q  [fir_pkg::NumPairs];
  logic signed [fir_pkg::PairW-1:0]  pair_d  [fir_pkg::NumPairs];
  logic signed [fir_pkg::OutW-1:0]   sum_d;
  logic [fir_pkg::OutW-1:0]          out_q;
  logic                              s1_valid_q, s2_valid_q, out_valid_q;
  logic                              advance;

  // Coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q[0] <= fir_pkg::CoeffReset0;
      for (int k = 1; k < fir_pkg::NumRegs; k++) begin
        coeff_q[k] <= fir_pkg::CoeffResetRest;
      end
    end else if (cfg_i.we) begin
      coeff_q[cfg_i.idx] <= cfg_i.data;
    end
  end

  // The whole pipeline moves when the output word is free or taken
  assign advance          = !out_valid_q || !filtered_stall_i;
  assign pop_o            = advance && valid_i;
  assign filtered_valid_o = out_valid_q;
  assign filtered_o       = out_q;

  // Stage 1: one multiplier per tap
  always_comb begin
    for (int i = 0; i < fir_pkg::Taps; i++) begin
      prod_d[i] = $signed(coeff_q[i]) * $signed(window_i[i]);
    end
  end

  // Stage 2: sum products in pairs
  for (genvar p = 0; p < fir_pkg::NumPairs; p++) begin : g_pair
    if (2 * p + 1 < fir_pkg::Taps) begin : g_two
      assign pair_d[p] = fir_pkg::PairW'(prod_q[2*p]) + fir_pkg::PairW'(prod_q[2*p+1]);
    end else begin : g_one
      assign pair_d[p] = fir_pkg::PairW'(prod_q[2*p]);
    end
  end

  // Stage 3: sum the pairs
  always_comb begin
    sum_d = '0;
    for (int p = 0; p < fir_pkg::NumPairs; p++) begin
      sum_d = sum_d + fir_pkg::OutW'(pair_q[p]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int i = 0; i < fir_pkg::Taps; i++) begin
        prod_q[i] <= prod_d[i];
      end
      for (int p = 0; p < fir_pkg::NumPairs; p++) begin
        pair_q[p] <= pair_d[p];
      end
      out_q <= sum_d;
    end
  end

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(s1_valid_q) && $stable(s2_valid_q) && $stable(out_q))
    else $error("pipeline moved while output stalled");

  a_stage_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && advance) |=> out_valid_q)
    else $error("word lost between sum stages");

endmodule

FILE: rtl/direct_form_fir_filter.sv
// Channel   Direction  Handshake                          Payload
// sample    in         sample_valid_i / sample_stall_o    sample_i [15:0] signed Q1.15
// filtered  out        filtered_valid_o / filtered_stall_i filtered_o [34:0] signed Q5.30
// cfg       in         cfg_we_i                           cfg_idx_i [2:0], cfg_data_i [15:0]
//
// One sample per cycle while sample_stall_o is low; each accepted sample passes through
// the queue, the multiply stage, the pair-sum stage and the final-sum output register.
// Reset clears the sample history and pipeline and sets coeff_0 to 32767, others to 0.
// A stalled output freezes the back pipeline; the two-entry queue then fills and
// sample_stall_o rises until the output word is taken.
module direct_form_fir_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            sample_valid_i,
  output logic                            sample_stall_o,
  input  logic [fir_pkg::SampleW-1:0]     sample_i,
  output logic                            filtered_valid_o,
  input  logic                            filtered_stall_i,
  output logic [fir_pkg::OutW-1:0]        filtered_o,
  input  logic                            cfg_we_i,
  input  logic [fir_pkg::RegIdxW-1:0]     cfg_idx_i,
  input  logic [fir_pkg::CoeffW-1:0]      cfg_data_i
);

  fir_pkg::window_t push_window, pop_window;
  fir_pkg::cfg_wr_t cfg;
  logic             push, pop, full, fifo_valid;

  // Bundle the configuration write
  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  fir_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_stall_o (sample_stall_o),
    .sample_i       (sample_i),
    .full_i         (full),
    .push_o         (push),
    .window_o       (push_window)
  );

  fir_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_window),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (fifo_valid),
    .pop_data_o  (pop_window)
  );

  fir_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .valid_i          (fifo_valid),
    .window_i         (pop_window),
    .pop_o            (pop),
    .filtered_valid_o (filtered_valid_o),
    .filtered_stall_i (filtered_stall_i),
    .filtered_o       (filtered_o)
  );

endmodule

FILE: tb/direct_form_fir_filter_chk.sv
`timescale 1ns / 100ps

module direct_form_fir_filter_chk (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        sample_valid_i,
  input  logic                        sample_stall_i,
  input  logic [fir_pkg::SampleW-1:0] sample_i,
  input  logic                        filtered_valid_i,
  input  logic                        filtered_stall_i,
  input  logic [fir_pkg::OutW-1:0]    filtered_i,
  input  logic                        cfg_we_i,
  input  logic [fir_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [fir_pkg::CoeffW-1:0]  cfg_data_i,
  output int                          pending_o,
  output int                          fail_count_o
);

  // Shadow copy of the coefficients and the sample delay line
  logic signed [fir_pkg::CoeffW-1:0]  coeff_q [fir_pkg::NumRegs];
  logic signed [fir_pkg::SampleW-1:0] delay_q [fir_pkg::Taps];
  logic [fir_pkg::OutW-1:0]           filtered_due_q [$];
  logic [fir_pkg::OutW-1:0]           want;
  int                                 fails;

  // Sum coefficient times delayed sample over all taps, full precision
  function automatic logic [fir_pkg::OutW-1:0] tap_sum();
    longint acc;
    acc = 0;
    for (int k = 0; k < fir_pkg::Taps; k++) begin
      acc += longint'(coeff_q[k]) * longint'(delay_q[k]);
    end
    return acc[fir_pkg::OutW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // Return coefficients to reset values, clear the delay line
      for (int k = 0; k < fir_pkg::NumRegs; k++) begin
        coeff_q[k] = (k == 0) ? fir_pkg::CoeffReset0 : fir_pkg::CoeffResetRest;
      end
      for (int k = 0; k < fir_pkg::Taps; k++) begin
        delay_q[k] = '0;
      end
      filtered_due_q.delete();
      fails = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      // Track coefficient writes
      if (cfg_we_i && (int'(cfg_idx_i) < fir_pkg::NumRegs)) begin
        coeff_q[cfg_idx_i] = cfg_data_i;
      end

      // Advance the delay line on each accepted sample word and predict its output
      if (sample_valid_i && !sample_stall_i) begin
        for (int k = fir_pkg::Taps - 1; k > 0; k--) begin
          delay_q[k] = delay_q[k-1];
        end
        delay_q[0] = sample_i;
        filtered_due_q.push_back(tap_sum());
      end

      // Compare each accepted output word with the oldest prediction
      if (filtered_valid_i && !filtered_stall_i) begin
        if (filtered_due_q.size() == 0) begin
          $display("%0t: unexpected filtered word, expected none, got %0d",
                   $time, $signed(filtered_i));
          fails++;
        end else begin
          want = filtered_due_q.pop_front();
          if (filtered_i !== want) begin
            $display("%0t: filtered mismatch, expected %0d, got %0d",
                     $time, $signed(want), $signed(filtered_i));
            fails++;
          end
        end
      end

      pending_o <= filtered_due_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

FILE: tb/direct_form_fir_filter_tb.sv
`timescale 1ns / 100ps

module direct_form_fir_filter_tb;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        sample_valid_i;
  logic                        sample_stall_o;
  logic [fir_pkg::SampleW-1:0] sample_i;
  logic                        filtered_valid_o;
  logic                        filtered_stall_i;
  logic [fir_pkg::OutW-1:0]    filtered_o;
  logic                        cfg_we_i;
  logic [fir_pkg::RegIdxW-1:0] cfg_idx_i;
  logic [fir_pkg::CoeffW-1:0]  cfg_data_i;

  int                          pending;
  int                          fail_count;
  int                          send_gap_max;
  int                          recv_gap_max;
  int                          hold_req;
  logic [fir_pkg::CoeffW-1:0]  coeff_set [fir_pkg::NumRegs];

  direct_form_fir_filter uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sample_valid_i   (sample_valid_i),
    .sample_stall_o   (sample_stall_o),
    .sample_i         (sample_i),
    .filtered_valid_o (filtered_valid_o),
    .filtered_stall_i (filtered_stall_i),
    .filtered_o       (filtered_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i)
  );

  direct_form_fir_filter_chk chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sample_valid_i   (sample_valid_i),
    .sample_stall_i   (sample_stall_o),
    .sample_i         (sample_i),
    .filtered_valid_i (filtered_valid_o),
    .filtered_stall_i (filtered_stall_i),
    .filtered_i       (filtered_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .pending_o        (pending),
    .fail_count_o     (fail_count)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Bound the run
  initial begin
    #2000000;
    $display("direct_form_fir_filter_tb: done, errors");
    $finish;
  end

  // Output side: stall a random number of cycles before each word, or hold off long on request
  initial begin
    int n;
    filtered_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
      end else begin
        n = $urandom_range(0, recv_gap_max);
      end
      if (n > 0) begin
        filtered_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      filtered_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!filtered_valid_o) @(posedge clk_i);
    end
  end

  // Offer one sample word after a random gap, hold it until taken
  task automatic send_sample(input logic [fir_pkg::SampleW-1:0] value);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      sample_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_i <= value;
    @(posedge clk_i);
    while (sample_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every predicted word has drained
  task automatic drain();
    sample_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the whole coefficient set, one register per cycle
  task automatic load_coeffs();
    for (int r = 0; r < fir_pkg::NumRegs; r++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= fir_pkg::RegIdxW'(r);
      cfg_data_i <= coeff_set[r];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_repeat(input logic [fir_pkg::SampleW-1:0] value, input int count);
    for (int k = 0; k < count; k++) send_sample(value);
  endtask

  // Mix full-scale, tiny and arbitrary samples
  function automatic logic [fir_pkg::SampleW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return fir_pkg::SampleW'($urandom_range(0, 15));
      3: return fir_pkg::SampleW'(-$signed($urandom_range(1, 16)));
      default: return fir_pkg::SampleW'($urandom);
    endcase
  endfunction

  function automatic logic [fir_pkg::CoeffW-1:0] pick_coeff();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return '0;
      default: return fir_pkg::CoeffW'($urandom);
    endcase
  endfunction

  initial begin
    logic [fir_pkg::SampleW-1:0] opening [5];
    int hot;

    rst_ni <= 1'b0;
    sample_valid_i <= 1'b0;
    sample_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    hold_req = 0;
    send_gap_max = 2;
    recv_gap_max = 2;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset coefficients pass the sample through; history starts at zero
    opening = '{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h0000};
    foreach (opening[k]) send_sample(opening[k]);
    drain();

    // Most positive output: every tap -1 times -1
    foreach (coeff_set[r]) coeff_set[r] = 16'h8000;
    load_coeffs();
    send_repeat(16'h8000, 8);
    drain();

    // Most negative output: every tap max times -1
    foreach (coeff_set[r]) coeff_set[r] = 16'h7FFF;
    load_coeffs();
    send_repeat(16'h8000, 8);
    drain();

    // Random phases with varying coefficient sets and idling
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: foreach (coeff_set[r]) coeff_set[r] = 16'h8000;
        1: foreach (coeff_set[r]) coeff_set[r] = 16'h7FFF;
        2: begin
          hot = $urandom_range(0, fir_pkg::NumRegs - 1);
          foreach (coeff_set[r]) coeff_set[r] = (r == hot) ? 16'h7FFF : 16'h0000;
        end
        default: foreach (coeff_set[r]) coeff_set[r] = pick_coeff();
      endcase
      load_coeffs();

      case (p % 3)
        0: begin
          send_gap_max = 0;
          recv_gap_max = 0;
        end
        1: begin
          send_gap_max = 8;
          recv_gap_max = 8;
        end
        default: begin
          send_gap_max = 0;
          recv_gap_max = 8;
        end
      endcase

      // Hold off the output long enough for the input to back up
      if (p == 4) begin
        send_gap_max = 0;
        hold_req = 300;
      end

      for (int k = 0; k < 133; k++) send_sample(pick_sample());
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("direct_form_fir_filter_tb: done, clean");
    end else begin
      $display("direct_form_fir_filter_tb: done, errors");
    end
    $finish;
  end

endmodule
